@@ rtl/dtf_pkg.sv @@
// shared types, constants and helper functions for the decimal text to float unit
package dtf_pkg;

    localparam int MAX_CHARS  = 16;
    localparam int NUM_LANES  = 8;
    localparam int LUT_CENTER = 16;
    localparam int NUM_STAGES = 17;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    // internal exponent: bit 31 of the mantissa weighs 2^(exp - 512)
    localparam logic [9:0] EXP_BIAS_SINGLE = 10'd385;
    localparam logic [9:0] EXP_BIAS_PROD   = 10'd393;

    typedef struct packed {
        logic        sign;
        logic [9:0]  exp;
        logic [31:0] mant;
    } op_t;

    function automatic logic [31:0] weight_lut(input logic [4:0] idx);
        logic [31:0] w;
        unique case (idx)
            5'd0:  w = 32'h58635FA9;
            5'd1:  w = 32'h56B5E621;
            5'd2:  w = 32'h551184E7;
            5'd3:  w = 32'h5368D4A5;
            5'd4:  w = 32'h51BA43B7;
            5'd5:  w = 32'h501502F9;
            5'd6:  w = 32'h4E6E6B28;
            5'd7:  w = 32'h4CBEBC20;
            5'd8:  w = 32'h4B189680;
            5'd9:  w = 32'h49742400;
            5'd10: w = 32'h47C35000;
            5'd11: w = 32'h461C4000;
            5'd12: w = 32'h447A0000;
            5'd13: w = 32'h42C80000;
            5'd14: w = 32'h41200000;
            5'd15: w = 32'h3F800000;
            5'd16: w = 32'h00000000;
            5'd17: w = 32'h3DCCCCCD;
            5'd18: w = 32'h3C23D70B;
            5'd19: w = 32'h3A83126F;
            5'd20: w = 32'h38D1B718;
            5'd21: w = 32'h3727C5AD;
            5'd22: w = 32'h358637BE;
            5'd23: w = 32'h33D6BF97;
            5'd24: w = 32'h322BCC79;
            5'd25: w = 32'h30897061;
            5'd26: w = 32'h2EDBE702;
            5'd27: w = 32'h2D2FEC02;
            5'd28: w = 32'h2B8CBCCF;
            5'd29: w = 32'h29E12E18;
            5'd30: w = 32'h283424E0;
            5'd31: w = 32'h26901D80;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc36(input logic [35:0] v);
        logic [5:0] n;
        n = 6'd36;
        for (int i = 0; i < 36; i++) begin
            if (v[i]) begin
                n = 6'(35 - i);
            end
        end
        return n;
    endfunction

    function automatic op_t f2op(input logic [31:0] f);
        op_t o;
        o.sign = f[31];
        o.exp  = {2'b00, f[30:23]} + EXP_BIAS_SINGLE;
        o.mant = (f[30:23] == 8'd0) ? 32'd0 : {1'b1, f[22:0], 8'd0};
        return o;
    endfunction

endpackage

@@ rtl/dtf_ctrl.sv @@
// valid chain, stage enables and sideband flags of the pipeline
module dtf_ctrl import dtf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [4:0]            body_length,
    input  logic                  negative,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [NUM_STAGES-1:0] stage_en,
    output logic                  neg_out,
    output logic                  fallback_out
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  neg_reg [NUM_STAGES];
    logic                  fb_reg  [NUM_STAGES];

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            stage_en[k] = m_tready ||
                ((valid_reg | NUM_STAGES'((64'd1 << k) - 64'd1)) != {NUM_STAGES{1'b1}});
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (k == 0) begin
                valid_next[k] = stage_en[k] ? s_tvalid : valid_reg[k];
            end else begin
                valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                if (k == 0) begin
                    neg_reg[k] <= negative;
                    fb_reg[k]  <= (body_length > 5'(MAX_CHARS));
                end else begin
                    neg_reg[k] <= neg_reg[k-1];
                    fb_reg[k]  <= fb_reg[k-1];
                end
            end
        end
    end

    assign s_tready     = stage_en[0];
    assign m_tvalid     = valid_reg[NUM_STAGES-1];
    assign neg_out      = neg_reg[NUM_STAGES-1];
    assign fallback_out = fb_reg[NUM_STAGES-1];

`ifndef SYNTH
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg == {NUM_STAGES{1'b1}}) && !m_tready) |-> !s_tready)
        else $error("full pipeline took a request while output stalled");

    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(s_tvalid && s_tready) && !$past(m_tvalid && m_tready))
        |-> ($countones(valid_reg) == $countones($past(valid_reg))))
        else $error("request lost or duplicated inside pipeline");

    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted request missing from first stage");
`endif

endmodule

@@ rtl/dtf_decode.sv @@
// point search, digit extraction and weight lookup stage
module dtf_decode import dtf_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [63:0]       text_low,
    input  logic [63:0]       text_high,
    input  logic [4:0]        body_length,
    output logic [31:0]       weight_q [MAX_CHARS],
    output logic [7:0]        digit_q  [MAX_CHARS]
);

    logic [7:0]  chars       [MAX_CHARS];
    logic [31:0] weight_next [MAX_CHARS];
    logic [7:0]  digit_next  [MAX_CHARS];
    logic [31:0] weight_reg  [MAX_CHARS];
    logic [7:0]  digit_reg   [MAX_CHARS];
    logic [4:0]  point;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            chars[i]             = text_low[8*i +: 8];
            chars[i + NUM_LANES] = text_high[8*i +: 8];
        end
        point = body_length;
        for (int i = MAX_CHARS - 1; i >= 0; i--) begin
            if ((5'(i) < body_length) && (chars[i] == CHAR_POINT)) begin
                point = 5'(i);
            end
        end
        for (int i = 0; i < MAX_CHARS; i++) begin
            digit_next[i]  = (5'(i) < body_length) ? (chars[i] - CHAR_ZERO) : 8'd0;
            weight_next[i] = weight_lut(5'(LUT_CENTER) - point + 5'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            weight_reg <= weight_next;
            digit_reg  <= digit_next;
        end
    end

    assign weight_q = weight_reg;
    assign digit_q  = digit_reg;

endmodule

@@ rtl/dtf_mul.sv @@
// exact weight by digit products, one lane per character
module dtf_mul import dtf_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] weight [MAX_CHARS],
    input  logic [7:0]  digit  [MAX_CHARS],
    output op_t         prod_q [MAX_CHARS]
);

    op_t        prod_next [MAX_CHARS];
    op_t        prod_reg  [MAX_CHARS];
    logic [7:0] mag       [MAX_CHARS];

    always_comb begin
        for (int i = 0; i < MAX_CHARS; i++) begin
            mag[i] = digit[i][7] ? (~digit[i] + 8'd1) : digit[i];
            prod_next[i].sign = digit[i][7];
            prod_next[i].exp  = {2'b00, weight[i][30:23]} + EXP_BIAS_PROD;
            prod_next[i].mant = (weight[i][30:23] == 8'd0) ? 32'd0 :
                                32'({1'b1, weight[i][22:0]}) * 32'(mag[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_q = prod_reg;

endmodule

@@ rtl/dtf_fadd.sv @@
// three stage exact sum of two operands, rounded to nearest even single
module dtf_fadd import dtf_pkg::*; (
    input  logic        aclk,
    input  logic [2:0]  en,
    input  op_t         a,
    input  op_t         b,
    output logic [31:0] result
);

    op_t         na_reg, nb_reg, na_next, nb_next;
    logic [5:0]  lz_a, lz_b;

    op_t         big, sml;
    logic        swap;
    logic [9:0]  diff;
    logic [5:0]  sh;
    logic [34:0] wide, shifted, lost, aligned;
    logic [35:0] sum_next, sum_reg;
    logic [9:0]  exp_reg;
    logic        sign_reg;

    logic [5:0]  lz;
    logic [35:0] norm;
    logic [23:0] mant24;
    logic        up;
    logic [24:0] rounded;
    logic [9:0]  exp_res;
    logic [31:0] result_next, result_reg;

    // operand normalisation
    always_comb begin
        lz_a         = lzc32(a.mant);
        lz_b         = lzc32(b.mant);
        na_next.sign = a.sign;
        na_next.exp  = a.exp - {4'd0, lz_a};
        na_next.mant = a.mant << lz_a;
        nb_next.sign = b.sign;
        nb_next.exp  = b.exp - {4'd0, lz_b};
        nb_next.mant = b.mant << lz_b;
    end

    // alignment with sticky and add
    always_comb begin
        swap    = {|nb_reg.mant, nb_reg.exp, nb_reg.mant} >
                  {|na_reg.mant, na_reg.exp, na_reg.mant};
        big     = swap ? nb_reg : na_reg;
        sml     = swap ? na_reg : nb_reg;
        diff    = big.exp - sml.exp;
        sh      = (diff[9:6] != 4'd0) ? 6'd63 : diff[5:0];
        wide    = {sml.mant, 3'b000};
        shifted = wide >> sh;
        lost    = wide & ~({35{1'b1}} << sh);
        aligned = shifted | {34'd0, |lost};
        if (big.sign ^ sml.sign) begin
            sum_next = {1'b0, big.mant, 3'b000} - {1'b0, aligned};
        end else begin
            sum_next = {1'b0, big.mant, 3'b000} + {1'b0, aligned};
        end
    end

    // normalise and round
    always_comb begin
        lz      = lzc36(sum_reg);
        norm    = sum_reg << lz;
        mant24  = norm[35:12];
        up      = norm[11] & ((|norm[10:0]) | mant24[0]);
        rounded = {1'b0, mant24} + {24'd0, up};
        exp_res = exp_reg + 10'd1 - {4'd0, lz} - EXP_BIAS_SINGLE + {9'd0, rounded[24]};
        if (sum_reg == 36'd0) begin
            result_next = 32'd0;
        end else begin
            result_next = {sign_reg, exp_res[7:0], rounded[24] ? 23'd0 : rounded[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            na_reg <= na_next;
            nb_reg <= nb_next;
        end
        if (en[1]) begin
            sum_reg  <= sum_next;
            exp_reg  <= big.exp;
            sign_reg <= big.sign;
        end
        if (en[2]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/decimal_text_to_float_unit.sv @@
// top level: decimal text of up to sixteen characters to single precision float
//
// input stream s_*: one request per text, s_tdata carries the characters after
// the sign, their count and the sign flag. output stream m_*: one request per
// input request, in order, with the float bit pattern and a fallback flag that
// is set (and the value zero) when the text is longer than sixteen characters.
// the datapath is a 17 stage pipeline: decode and weight lookup, products,
// then three stage float adders for the lane products, the fused lane pairs
// and the three levels of the sum tree. one request is taken per cycle while
// the output drains. a stage holds only while it and every later stage are
// full and m_tready is low, so empty stages still fill when a request waits
// at the output; nothing is lost or repeated. reset (aresetn low at a clock
// edge) empties the pipeline only.
module decimal_text_to_float_unit import dtf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // text_low, text_high, body_length, negative
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // value_bits, needs_fallback
);

    logic [NUM_STAGES-1:0] stage_en;
    logic                  neg_out;
    logic                  fallback_out;

    logic [31:0] weight [MAX_CHARS];
    logic [7:0]  digit  [MAX_CHARS];
    op_t         prod   [MAX_CHARS];

    op_t         hi_d1_reg [NUM_LANES];
    op_t         hi_d2_reg [NUM_LANES];
    op_t         hi_d3_reg [NUM_LANES];

    logic [31:0] lane_m   [NUM_LANES];
    logic [31:0] lane_s   [NUM_LANES];
    logic [31:0] level1   [4];
    logic [31:0] level2   [2];
    logic [31:0] total;

    op_t         zero_op;

    assign zero_op = '{sign: 1'b0, exp: 10'd0, mant: 32'd0};

    dtf_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .body_length  (s_tdata[132:128]),
        .negative     (s_tdata[133]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .stage_en     (stage_en),
        .neg_out      (neg_out),
        .fallback_out (fallback_out)
    );

    dtf_decode u_decode (
        .aclk        (aclk),
        .en          (stage_en[0]),
        .text_low    (s_tdata[63:0]),
        .text_high   (s_tdata[127:64]),
        .body_length (s_tdata[132:128]),
        .weight_q    (weight),
        .digit_q     (digit)
    );

    dtf_mul u_mul (
        .aclk   (aclk),
        .en     (stage_en[1]),
        .weight (weight),
        .digit  (digit),
        .prod_q (prod)
    );

    // upper lane products wait while the lower lanes are rounded
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (stage_en[2]) begin
                hi_d1_reg[i] <= prod[i + NUM_LANES];
            end
            if (stage_en[3]) begin
                hi_d2_reg[i] <= hi_d1_reg[i];
            end
            if (stage_en[4]) begin
                hi_d3_reg[i] <= hi_d2_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dtf_fadd u_round (
            .aclk   (aclk),
            .en     (stage_en[4:2]),
            .a      (prod[g]),
            .b      (zero_op),
            .result (lane_m[g])
        );

        dtf_fadd u_fused (
            .aclk   (aclk),
            .en     (stage_en[7:5]),
            .a      (hi_d3_reg[g]),
            .b      (f2op(lane_m[g])),
            .result (lane_s[g])
        );
    end

    dtf_fadd u_l1_0 (.aclk(aclk), .en(stage_en[10:8]), .a(f2op(lane_s[4])),
                     .b(f2op(lane_s[5])), .result(level1[0]));
    dtf_fadd u_l1_1 (.aclk(aclk), .en(stage_en[10:8]), .a(f2op(lane_s[0])),
                     .b(f2op(lane_s[1])), .result(level1[1]));
    dtf_fadd u_l1_2 (.aclk(aclk), .en(stage_en[10:8]), .a(f2op(lane_s[6])),
                     .b(f2op(lane_s[7])), .result(level1[2]));
    dtf_fadd u_l1_3 (.aclk(aclk), .en(stage_en[10:8]), .a(f2op(lane_s[2])),
                     .b(f2op(lane_s[3])), .result(level1[3]));

    dtf_fadd u_l2_0 (.aclk(aclk), .en(stage_en[13:11]), .a(f2op(level1[0])),
                     .b(f2op(level1[1])), .result(level2[0]));
    dtf_fadd u_l2_1 (.aclk(aclk), .en(stage_en[13:11]), .a(f2op(level1[2])),
                     .b(f2op(level1[3])), .result(level2[1]));

    dtf_fadd u_l3 (.aclk(aclk), .en(stage_en[16:14]), .a(f2op(level2[0])),
                   .b(f2op(level2[1])), .result(total));

    assign m_tdata[31:0]  = fallback_out ? 32'd0 : (total ^ {neg_out, 31'd0});
    assign m_tdata[32]    = fallback_out;
    assign m_tdata[39:33] = 7'd0;

endmodule
